[hw/rtl/lfpd_pkg.sv]
// Package for the line-follower PD drive controller.
// Holds the command, action, phase and mode codes, the channel payload types
// and the fixed ramp constants. No dependencies.
`default_nettype none

package lfpd_pkg;

    // Command codes carried by an input transaction.
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_MANUAL     = 2'd1;
    localparam logic [1:0] CMD_AUTO       = 2'd2;
    localparam logic [1:0] CMD_SET_ACTION = 2'd3;

    // Motor action codes.
    localparam logic [2:0] ACT_IDLE   = 3'd0;
    localparam logic [2:0] ACT_FWD    = 3'd1;
    localparam logic [2:0] ACT_BACK   = 3'd2;
    localparam logic [2:0] ACT_LEFT   = 3'd3;
    localparam logic [2:0] ACT_RIGHT  = 3'd4;
    localparam logic [2:0] ACT_STOP   = 3'd5;
    localparam logic [2:0] ACT_SPEEDS = 3'd6;
    localparam logic [2:0] ACT_NONE   = 3'd7;

    // Auto-mode phase codes.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ACCEL  = 3'd1;
    localparam logic [2:0] PH_PD     = 3'd2;
    localparam logic [2:0] PH_HLEFT  = 3'd3;
    localparam logic [2:0] PH_HRIGHT = 3'd4;
    localparam logic [2:0] PH_TURN   = 3'd5;
    localparam logic [2:0] PH_STOP   = 3'd6;

    // Drive mode codes.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_AUTO   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SETPOINT   = 3'd0;
    localparam logic [2:0] CFG_DEADBAND   = 3'd1;
    localparam logic [2:0] CFG_PROP_GAIN  = 3'd2;
    localparam logic [2:0] CFG_DERIV_GAIN = 3'd3;
    localparam logic [2:0] CFG_LEFT_LIMIT = 3'd4;
    localparam logic [2:0] CFG_RIGHT_LIMIT= 3'd5;
    localparam logic [2:0] CFG_STOP_HOLD  = 3'd6;
    localparam logic [2:0] CFG_TURN_HOLD  = 3'd7;

    // Ramp settings and the fixed recovery positions.
    localparam logic [15:0] RAMP_TARGET   = 16'd150;
    localparam logic [15:0] RAMP_STEP     = 16'd5;
    localparam logic [31:0] RAMP_INTERVAL = 32'd20;
    localparam logic [15:0] HLEFT_EXIT    = 16'd2500;
    localparam logic [15:0] HRIGHT_EXIT   = 16'd1500;

    // Largest stored manual action that drives the motors.
    localparam logic [2:0] ACT_LAST_MANUAL = ACT_STOP;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] time_now;
        logic [15:0] line_position;
        logic        all_dark;
        logic [2:0]  manual_choice;
    } cmd_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic [2:0]         motor_action;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [2:0]         auto_phase;
        logic [1:0]         drive_mode;
    } res_item_t;

    // Loop settings handed to the PD datapath.
    typedef struct packed {
        logic [15:0] line_setpoint;
        logic [15:0] error_deadband;
        logic [15:0] prop_gain;
        logic [15:0] deriv_gain;
    } pd_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/lfpd_if.sv]
// Valid/ready channel interfaces for the command and result streams.
// Depends on lfpd_pkg for the payload types.
`default_nettype none

interface lfpd_cmd_if;
    logic                valid;
    logic                ready;
    lfpd_pkg::cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lfpd_res_if;
    logic                valid;
    logic                ready;
    lfpd_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/lfpd_pd_calc.sv]
// PD steering datapath: error with deadband, Q8.8 gains, error-dependent base
// and saturated wheel speeds. Purely combinational; depends on lfpd_pkg.
`default_nettype none

module lfpd_pd_calc (
    input  wire lfpd_pkg::pd_cfg_t cfg,
    input  wire logic [15:0]        line_position,
    input  wire logic signed [16:0] previous_error,
    output logic signed [16:0]      error_used,
    output logic signed [15:0]      left_speed,
    output logic signed [15:0]      right_speed
);

    logic signed [16:0] err_raw;
    logic [15:0]        mag_raw;
    logic               in_deadband;
    logic [15:0]        mag_used;
    logic signed [33:0] prop_term;
    logic signed [17:0] err_diff;
    logic signed [34:0] deriv_term;
    logic signed [35:0] pd_sum;
    logic signed [27:0] adjust;
    logic [20:0]        mag_x31;
    logic [15:0]        base_diff;
    logic signed [28:0] base;
    logic signed [28:0] left_wide;
    logic signed [28:0] right_wide;

    function automatic logic signed [15:0] sat16(input logic signed [28:0] v);
        logic signed [15:0] r;
        if (v > 29'sd32767)
            r = 16'sh7FFF;
        else if (v < -29'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Error and its magnitude; small errors are forced to zero.
    always_comb
    begin
        err_raw     = $signed({1'b0, cfg.line_setpoint}) - $signed({1'b0, line_position});
        mag_raw     = err_raw[16] ? 16'(-err_raw) : err_raw[15:0];
        in_deadband = mag_raw < cfg.error_deadband;
        error_used  = in_deadband ? 17'sd0 : err_raw;
        mag_used    = in_deadband ? 16'd0 : mag_raw;
    end

    // Proportional and derivative terms, then division by 256 toward zero.
    always_comb
    begin
        prop_term  = 34'(error_used) * 34'($signed({1'b0, cfg.prop_gain}));
        err_diff   = 18'(error_used) - 18'(previous_error);
        deriv_term = 35'(err_diff) * 35'($signed({1'b0, cfg.deriv_gain}));
        pd_sum     = 36'(prop_term) + 36'(deriv_term);
        if (pd_sum[35])
            adjust = 28'((pd_sum + 36'sd255) >>> 8);
        else
            adjust = 28'(pd_sum >>> 8);
    end

    // Base speed 150 - 31/256 * |error|, floored at 40; it cannot exceed 150.
    always_comb
    begin
        mag_x31   = 21'(mag_used) * 21'd31;
        base_diff = 16'(21'd38400 - mag_x31);
        if (mag_x31 > 21'd28160)
            base = 29'sd40;
        else
            base = $signed({21'd0, base_diff[15:8]});
    end

    // Wheel speeds with 16-bit saturation.
    always_comb
    begin
        left_wide   = base - 29'(adjust);
        right_wide  = base + 29'(adjust);
        left_speed  = sat16(left_wide);
        right_speed = sat16(right_wide);
    end

endmodule

`default_nettype wire

[hw/rtl/line_follow_pd_mode_controller.sv]
// Top level of the line-follower drive controller: mode and phase state,
// configuration registers, input and result registers.
// Depends on lfpd_pkg, lfpd_if and lfpd_pd_calc.
//
//   Channel     Kind            Payload
//   command_ch  valid/ready in  command, time_now, line_position, all_dark,
//                               manual_choice
//   result_ch   valid/ready out motor_action, left_speed, right_speed,
//                               auto_phase, drive_mode
//   cfg_*       write only      cfg_index selects one of eight registers
//
// One transaction per cycle sustained while result_ch.ready stays high; a command
// taken is held in the input register and then moves on to the result register,
// from which its result is taken (input register, then result register).
// The whole step, including the two gain multiplies, sits between the two
// registers, so every command sees the state left by the one before it.
// Reset clears the mode, phase and timing state and loads the register defaults.
// A stalled result holds its register; command_ch.ready drops only when both
// the input and result registers are full and result_ch.ready is low.
`default_nettype none

module line_follow_pd_mode_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lfpd_cmd_if.sink         command_ch,
    lfpd_res_if.source       result_ch,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    // Configuration registers.
    lfpd_pkg::pd_cfg_t pd_cfg_reg;
    logic [15:0]       left_limit_reg;
    logic [15:0]       right_limit_reg;
    logic [31:0]       stop_hold_reg;
    logic [31:0]       turn_hold_reg;

    // Controller state.
    logic [1:0]         mode_reg, mode_next;
    logic [2:0]         manual_action_reg, manual_action_next;
    logic [2:0]         phase_reg, phase_next;
    logic [31:0]        phase_entry_reg, phase_entry_next;
    logic [31:0]        ramp_timer_reg, ramp_timer_next;
    logic [15:0]        drive_level_reg, drive_level_next;
    logic signed [16:0] prev_error_reg, prev_error_next;
    logic [31:0]        last_time_reg, last_time_next;

    // Pipeline registers and handshake.
    logic                s1_valid_reg;
    lfpd_pkg::cmd_item_t s1_data_reg;
    logic                res_valid_reg;
    lfpd_pkg::res_item_t res_data_reg;
    lfpd_pkg::res_item_t res_next;
    logic                s1_go;
    logic                s1_fire;

    // PD datapath results and step temporaries.
    logic signed [16:0] pd_error;
    logic signed [15:0] pd_left;
    logic signed [15:0] pd_right;
    logic [31:0]        elapsed;
    logic [31:0]        ramp_elapsed;
    logic [15:0]        level_stepped;
    logic [2:0]         act;
    logic signed [15:0] ls;
    logic signed [15:0] rs;

    lfpd_pd_calc u_pd_calc (
        .cfg            (pd_cfg_reg),
        .line_position  (s1_data_reg.line_position),
        .previous_error (prev_error_reg),
        .error_used     (pd_error),
        .left_speed     (pd_left),
        .right_speed    (pd_right)
    );

    // Handshake: the input stage moves whenever the result register is empty or being taken.
    assign s1_go            = !res_valid_reg || result_ch.ready;
    assign s1_fire          = s1_valid_reg && s1_go;
    assign command_ch.ready = !s1_valid_reg || s1_go;
    assign result_ch.valid  = res_valid_reg;
    assign result_ch.data   = res_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pd_cfg_reg.line_setpoint  <= 16'd2000;
            pd_cfg_reg.error_deadband <= 16'd50;
            pd_cfg_reg.prop_gain      <= 16'd256;
            pd_cfg_reg.deriv_gain     <= 16'd0;
            left_limit_reg            <= 16'd3500;
            right_limit_reg           <= 16'd500;
            stop_hold_reg             <= 32'd1000;
            turn_hold_reg             <= 32'd1000;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lfpd_pkg::CFG_SETPOINT:    pd_cfg_reg.line_setpoint  <= cfg_wdata[15:0];
                lfpd_pkg::CFG_DEADBAND:    pd_cfg_reg.error_deadband <= cfg_wdata[15:0];
                lfpd_pkg::CFG_PROP_GAIN:   pd_cfg_reg.prop_gain      <= cfg_wdata[15:0];
                lfpd_pkg::CFG_DERIV_GAIN:  pd_cfg_reg.deriv_gain     <= cfg_wdata[15:0];
                lfpd_pkg::CFG_LEFT_LIMIT:  left_limit_reg            <= cfg_wdata[15:0];
                lfpd_pkg::CFG_RIGHT_LIMIT: right_limit_reg           <= cfg_wdata[15:0];
                lfpd_pkg::CFG_STOP_HOLD:   stop_hold_reg             <= cfg_wdata;
                lfpd_pkg::CFG_TURN_HOLD:   turn_hold_reg             <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Step logic: command decode and the auto-mode phase machine.
    always_comb
    begin
        mode_next          = mode_reg;
        manual_action_next = manual_action_reg;
        phase_next         = phase_reg;
        phase_entry_next   = phase_entry_reg;
        ramp_timer_next    = ramp_timer_reg;
        drive_level_next   = drive_level_reg;
        prev_error_next    = prev_error_reg;
        last_time_next     = last_time_reg;
        act                = lfpd_pkg::ACT_NONE;
        ls                 = 16'sd0;
        rs                 = 16'sd0;
        elapsed            = s1_data_reg.time_now - phase_entry_reg;
        ramp_elapsed       = s1_data_reg.time_now - ramp_timer_reg;
        level_stepped      = drive_level_reg + lfpd_pkg::RAMP_STEP;

        if (s1_fire)
        begin
            unique case (s1_data_reg.command)
                lfpd_pkg::CMD_MANUAL:
                begin
                    mode_next          = lfpd_pkg::MODE_MANUAL;
                    manual_action_next = lfpd_pkg::ACT_IDLE;
                end
                lfpd_pkg::CMD_AUTO:
                begin
                    mode_next        = lfpd_pkg::MODE_AUTO;
                    phase_next       = lfpd_pkg::PH_ACCEL;
                    phase_entry_next = last_time_reg;
                    drive_level_next = 16'd0;
                end
                lfpd_pkg::CMD_SET_ACTION:
                begin
                    manual_action_next = s1_data_reg.manual_choice;
                end
                default:
                begin
                    last_time_next = s1_data_reg.time_now;
                    if (mode_reg == lfpd_pkg::MODE_MANUAL)
                    begin
                        act = (manual_action_reg <= lfpd_pkg::ACT_LAST_MANUAL)
                            ? manual_action_reg : lfpd_pkg::ACT_NONE;
                    end
                    else if (mode_reg != lfpd_pkg::MODE_AUTO)
                    begin
                        act = lfpd_pkg::ACT_IDLE;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            lfpd_pkg::PH_IDLE:
                            begin
                                act = lfpd_pkg::ACT_IDLE;
                                if (elapsed > stop_hold_reg)
                                begin
                                    phase_next       = lfpd_pkg::PH_ACCEL;
                                    phase_entry_next = s1_data_reg.time_now;
                                    drive_level_next = 16'd0;
                                end
                            end
                            lfpd_pkg::PH_ACCEL:
                            begin
                                if (drive_level_reg >= lfpd_pkg::RAMP_TARGET)
                                begin
                                    phase_next       = lfpd_pkg::PH_PD;
                                    phase_entry_next = s1_data_reg.time_now;
                                    prev_error_next  = 17'sd0;
                                end
                                else if (ramp_elapsed >= lfpd_pkg::RAMP_INTERVAL)
                                begin
                                    drive_level_next = level_stepped;
                                    act              = lfpd_pkg::ACT_SPEEDS;
                                    ls = level_stepped[15] ? 16'sh7FFF : $signed(level_stepped);
                                    rs = ls;
                                    ramp_timer_next  = s1_data_reg.time_now;
                                end
                            end
                            lfpd_pkg::PH_PD:
                            begin
                                if (s1_data_reg.all_dark)
                                begin
                                    phase_next       = lfpd_pkg::PH_STOP;
                                    phase_entry_next = s1_data_reg.time_now;
                                end
                                else if (s1_data_reg.line_position > left_limit_reg)
                                begin
                                    phase_next       = lfpd_pkg::PH_HLEFT;
                                    phase_entry_next = s1_data_reg.time_now;
                                end
                                else if (s1_data_reg.line_position < right_limit_reg)
                                begin
                                    phase_next       = lfpd_pkg::PH_HRIGHT;
                                    phase_entry_next = s1_data_reg.time_now;
                                end
                                else
                                begin
                                    act             = lfpd_pkg::ACT_SPEEDS;
                                    ls              = pd_left;
                                    rs              = pd_right;
                                    prev_error_next = pd_error;
                                end
                            end
                            lfpd_pkg::PH_HLEFT:
                            begin
                                act = lfpd_pkg::ACT_LEFT;
                                if (s1_data_reg.line_position <= lfpd_pkg::HLEFT_EXIT)
                                begin
                                    phase_next       = lfpd_pkg::PH_PD;
                                    phase_entry_next = s1_data_reg.time_now;
                                    prev_error_next  = 17'sd0;
                                end
                            end
                            lfpd_pkg::PH_HRIGHT:
                            begin
                                act = lfpd_pkg::ACT_RIGHT;
                                if (s1_data_reg.line_position > lfpd_pkg::HRIGHT_EXIT)
                                begin
                                    phase_next       = lfpd_pkg::PH_PD;
                                    phase_entry_next = s1_data_reg.time_now;
                                    prev_error_next  = 17'sd0;
                                end
                            end
                            lfpd_pkg::PH_TURN:
                            begin
                                if (elapsed > turn_hold_reg)
                                begin
                                    phase_next       = lfpd_pkg::PH_ACCEL;
                                    phase_entry_next = s1_data_reg.time_now;
                                    drive_level_next = 16'd0;
                                end
                                else
                                begin
                                    act = lfpd_pkg::ACT_RIGHT;
                                end
                            end
                            lfpd_pkg::PH_STOP:
                            begin
                                act = lfpd_pkg::ACT_STOP;
                                if (elapsed > stop_hold_reg)
                                begin
                                    phase_next       = lfpd_pkg::PH_TURN;
                                    phase_entry_next = s1_data_reg.time_now;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end

        res_next.motor_action = act;
        res_next.left_speed   = ls;
        res_next.right_speed  = rs;
        res_next.auto_phase   = phase_next;
        res_next.drive_mode   = mode_next;
    end

    // Controller state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= lfpd_pkg::MODE_NONE;
            manual_action_reg <= lfpd_pkg::ACT_IDLE;
            phase_reg         <= lfpd_pkg::PH_IDLE;
            phase_entry_reg   <= 32'd0;
            ramp_timer_reg    <= 32'd0;
            drive_level_reg   <= 16'd0;
            prev_error_reg    <= 17'sd0;
            last_time_reg     <= 32'd0;
        end
        else
        begin
            mode_reg          <= mode_next;
            manual_action_reg <= manual_action_next;
            phase_reg         <= phase_next;
            phase_entry_reg   <= phase_entry_next;
            ramp_timer_reg    <= ramp_timer_next;
            drive_level_reg   <= drive_level_next;
            prev_error_reg    <= prev_error_next;
            last_time_reg     <= last_time_next;
        end
    end

    // Input register valid flag and result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (command_ch.ready)
                s1_valid_reg <= command_ch.valid;
            if (s1_go)
                res_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (command_ch.valid && command_ch.ready)
            s1_data_reg <= command_ch.data;
        if (s1_fire)
            res_data_reg <= res_next;
    end

    // A command other than a tick always yields a result with no motor call.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_data_reg.command != lfpd_pkg::CMD_TICK)
        |=> (res_valid_reg && res_data_reg.motor_action == lfpd_pkg::ACT_NONE))
        else $error("non-tick command gave a motor call");

    // Speeds are zero unless the result sets speeds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.motor_action != lfpd_pkg::ACT_SPEEDS)
        |-> (res_data_reg.left_speed == 16'sd0 && res_data_reg.right_speed == 16'sd0))
        else $error("nonzero speed without a set-speeds action");

    // Set-speeds results only come from auto mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.motor_action == lfpd_pkg::ACT_SPEEDS)
        |-> (res_data_reg.drive_mode == lfpd_pkg::MODE_AUTO))
        else $error("set-speeds result outside auto mode");

    // The ramp never overshoots the target by a full step.
    assert property (@(posedge clk) disable iff (!rst_n)
        drive_level_reg < (lfpd_pkg::RAMP_TARGET + lfpd_pkg::RAMP_STEP))
        else $error("drive level ramped past its limit");

    // Back-pressure reaches the command side only with both stages full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !command_ch.ready |-> (s1_valid_reg && res_valid_reg && !result_ch.ready))
        else $error("command channel stalled with room in the pipeline");

endmodule

`default_nettype wire
